// ----- rtl/fee_pkg.sv -----
// Shared widths, register indexes and sequencer states of the flight energy estimator.
package fee_pkg;

    localparam int POS_W      = 32;
    localparam int VEL_W      = 24;
    localparam int GS_W       = 25;
    localparam int DELTA_W    = 40;
    localparam int TOTAL_W    = 48;
    localparam int HOVER_W    = 16;
    localparam int COEF_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier operand width and the square root radicand width.
    localparam int MUL_W      = 34;
    localparam int RAD_W      = 68;
    localparam int ROOT_W     = 34;
    localparam int SQ_STEPS   = 34;

    // Step energy numerator width and number of divider steps.
    localparam int NUM_W      = 82;
    localparam int DIV_STEPS  = 82;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_POWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [HOVER_W-1:0] HOVER_RESET = 16'd2400;
    localparam logic [VEL_W-1:0]   WIND_RESET  = 24'd0;
    localparam logic [COEF_W-1:0]  C0_RESET    = 20'd65805;
    localparam logic [COEF_W-1:0]  C1_RESET    = 20'hFFF69;
    localparam logic [COEF_W-1:0]  C2_RESET    = 20'hFFDFA;
    localparam logic [COEF_W-1:0]  C3_RESET    = 20'd72;

    // Sequencer states.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_VSQ   = 10'b0000000010,
        S_GSQRT = 10'b0000000100,
        S_POLY  = 10'b0000001000,
        S_PWR   = 10'b0000010000,
        S_DSQ   = 10'b0000100000,
        S_DSQRT = 10'b0001000000,
        S_PROD  = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

endpackage

// ----- rtl/fee_in_if.sv -----
// Input channel carrying one navigation sample item.
interface fee_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fee_pkg::POS_W-1:0]    pos_north;
    logic signed [fee_pkg::POS_W-1:0]    pos_east;
    logic signed [fee_pkg::POS_W-1:0]    pos_down;
    logic signed [fee_pkg::VEL_W-1:0]    vel_north;
    logic signed [fee_pkg::VEL_W-1:0]    vel_east;
    logic signed [fee_pkg::VEL_W-1:0]    vel_down;
    logic                                sample_valid;
    logic                                restart;

    modport source (output valid, pos_north, pos_east, pos_down, vel_north, vel_east,
                    vel_down, sample_valid, restart, input ready);
    modport sink   (input valid, pos_north, pos_east, pos_down, vel_north, vel_east,
                    vel_down, sample_valid, restart, output ready);
endinterface

// ----- rtl/fee_out_if.sv -----
// Output channel carrying one energy result item.
interface fee_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fee_pkg::DELTA_W-1:0]  delta_energy;
    logic signed [fee_pkg::TOTAL_W-1:0]  total_energy;
    logic        [fee_pkg::GS_W-1:0]     ground_speed;
    logic                                zero_speed;
    logic                                sample_held;

    modport source (output valid, delta_energy, total_energy, ground_speed, zero_speed,
                    sample_held, input ready);
    modport sink   (input valid, delta_energy, total_energy, ground_speed, zero_speed,
                    sample_held, output ready);
endinterface

// ----- rtl/fee_sqrt.sv -----
// Iterative floor square root, two radicand bits per cycle.
module fee_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fee_pkg::RAD_W-1:0]    i_radicand,
    output logic                         o_done,
    output logic [fee_pkg::ROOT_W-1:0]   o_root
);
    import fee_pkg::*;

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+3:0] trial_in;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    // One restoring step: bring down two bits and try root*4+1.
    assign trial_in = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign ge       = (trial_in >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= ge ? (ROOT_W+2)'(trial_in - trial) : (ROOT_W+2)'(trial_in);
                r_root <= {r_root[ROOT_W-2:0], ge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(SQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/flight_energy_estimator_top.sv -----
// Flight energy estimator: one result item per navigation sample item.
//
// The block takes one sample at a time and is not ready while it works. A sample
// that yields a step energy passes through the speed squares, the ground speed
// root, the polynomial and power, the distance squares, the distance root, the
// energy product and the bit-serial division, and then updates the total. All
// products go through one shared 34 by 34 bit multiplier and both roots through
// one iterative square root unit. A sample that gives no step energy (first
// sample, restart or zero ground speed) finishes after the ground speed root. The
// result is held in an output register until taken.
module flight_energy_estimator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fee_in_if.sink                             i_item,
    fee_out_if.source                          o_result,
    input  logic                               i_cfg_we,
    input  logic [fee_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fee_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fee_pkg::*;

    // Configuration registers.
    logic [HOVER_W-1:0]        r_hover;
    logic signed [VEL_W-1:0]   r_wind;
    logic signed [COEF_W-1:0]  r_c0, r_c1, r_c2, r_c3;

    // Stored reference sample and running total.
    logic signed [POS_W-1:0]   r_last_n, r_last_e, r_last_d;
    logic signed [VEL_W-1:0]   r_last_vn, r_last_ve, r_last_vd;
    logic                      r_have_ref;
    logic signed [TOTAL_W-1:0] r_sum;

    // Working sample.
    logic signed [POS_W-1:0]   r_cur_n, r_cur_e, r_cur_d;
    logic signed [VEL_W-1:0]   r_cur_vn, r_cur_ve, r_cur_vd;
    logic                      r_valid_s;
    logic                      r_restart;

    // Sequencer and datapath registers.
    t_state                    r_state;
    logic [6:0]                r_cnt;
    logic [2*MUL_W-1:0]        r_prod;
    logic [RAD_W-1:0]          r_acc;
    logic [GS_W-1:0]           r_gs;
    logic signed [26:0]        r_air;
    logic signed [31:0]        r_p;
    logic [47:0]               r_mag;
    logic                      r_neg;
    logic [ROOT_W-1:0]         r_dist;
    logic [NUM_W-1:0]          r_num;
    logic [37:0]               r_rem;
    logic [39:0]               r_q;
    logic                      r_big;
    logic                      r_calc;

    // Output register.
    logic                      r_ovalid;
    logic signed [DELTA_W-1:0] r_odelta;
    logic signed [TOTAL_W-1:0] r_ototal;
    logic [GS_W-1:0]           r_ogs;
    logic                      r_ozero;
    logic                      r_oheld;

    logic [MUL_W-1:0]          mul_a, mul_b;
    logic [1:0]                idx;
    logic [VEL_W-1:0]          vel_abs [3];
    logic [32:0]               pos_abs [3];
    logic [31:0]               p_abs;
    logic [25:0]               air_abs;
    logic                      sq_start;
    logic                      sq_done;
    logic [ROOT_W-1:0]         sq_root;
    logic signed [58:0]        poly_prod;
    logic signed [42:0]        poly_sh;
    logic signed [COEF_W-1:0]  poly_c;
    logic signed [43:0]        poly_sum;
    logic signed [31:0]        poly_sat;
    logic [38:0]               div_t;
    logic [38:0]               div_d;
    logic                      div_ge;
    logic signed [DELTA_W-1:0] delta;
    logic signed [TOTAL_W-1:0] sum_base;
    logic signed [TOTAL_W:0]   total_raw;
    logic signed [TOTAL_W-1:0] total_sat;
    logic                      out_free;

    assign idx = r_cnt[2:1];

    // Magnitudes of the velocity components and position steps.
    always_comb begin
        logic signed [VEL_W-1:0] v [3];
        logic signed [32:0]      dp [3];
        v[0]  = r_cur_vn;
        v[1]  = r_cur_ve;
        v[2]  = r_cur_vd;
        dp[0] = 33'(r_cur_n) - 33'(r_last_n);
        dp[1] = 33'(r_cur_e) - 33'(r_last_e);
        dp[2] = 33'(r_cur_d) - 33'(r_last_d);
        for (int k = 0; k < 3; k++) begin
            vel_abs[k] = v[k][VEL_W-1] ? VEL_W'(-v[k]) : VEL_W'(v[k]);
            pos_abs[k] = dp[k][32] ? 33'(-dp[k]) : 33'(dp[k]);
        end
    end

    assign p_abs   = r_p[31] ? 32'(-r_p) : 32'(r_p);
    assign air_abs = r_air[26] ? 26'(-r_air) : 26'(r_air);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_VSQ: begin
                mul_a = MUL_W'(vel_abs[idx]);
                mul_b = MUL_W'(vel_abs[idx]);
            end
            S_POLY: begin
                mul_a = MUL_W'(p_abs);
                mul_b = MUL_W'(air_abs);
            end
            S_PWR: begin
                mul_a = MUL_W'(p_abs);
                mul_b = MUL_W'(r_hover);
            end
            S_DSQ: begin
                mul_a = MUL_W'(pos_abs[idx]);
                mul_b = MUL_W'(pos_abs[idx]);
            end
            S_PROD: begin
                mul_a = r_cnt[1] ? MUL_W'(r_mag[47:24]) : MUL_W'(r_mag[23:0]);
                mul_b = r_dist;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One Horner stage: floor(p*a / 2^16) + c, saturated to 32 bits.
    always_comb begin
        case (idx)
            2'd0:    poly_c = r_c2;
            2'd1:    poly_c = r_c1;
            default: poly_c = r_c0;
        endcase
        poly_prod = (r_p[31] ^ r_air[26]) ? -$signed({1'b0, r_prod[57:0]})
                                          : $signed({1'b0, r_prod[57:0]});
        poly_sh   = poly_prod[58:16];
        poly_sum  = 44'(poly_sh) + 44'(poly_c);
        if (poly_sum > 44'sh0007FFFFFFF) begin
            poly_sat = 32'sh7FFFFFFF;
        end else if (poly_sum < -44'sh00080000000) begin
            poly_sat = -32'sh80000000;
        end else begin
            poly_sat = poly_sum[31:0];
        end
    end

    // Restoring divider step on numerator / (ground speed * 2^12).
    assign div_t  = {r_rem, r_num[NUM_W-1]};
    assign div_d  = {2'b00, r_gs, 12'd0};
    assign div_ge = (div_t >= div_d);

    // Signed, saturated step energy and the new total.
    always_comb begin
        logic sat;
        sat = r_big | r_q[39];
        if (!r_calc) begin
            delta = '0;
        end else if (r_neg) begin
            delta = sat ? -40'sh8000000000 : -$signed({1'b0, r_q[38:0]});
        end else begin
            delta = sat ? 40'sh7FFFFFFFFF : $signed({1'b0, r_q[38:0]});
        end
        sum_base  = r_restart ? '0 : r_sum;
        total_raw = (TOTAL_W+1)'(sum_base) + (TOTAL_W+1)'(delta);
        if (total_raw[TOTAL_W] != total_raw[TOTAL_W-1]) begin
            total_sat = total_raw[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                           : {1'b0, {(TOTAL_W-1){1'b1}}};
        end else begin
            total_sat = total_raw[TOTAL_W-1:0];
        end
    end

    assign out_free = !r_ovalid || o_result.ready;
    assign sq_start = ((r_state == S_GSQRT) || (r_state == S_DSQRT)) && (r_cnt == 7'd0);

    fee_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_acc),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hover <= HOVER_RESET;
            r_wind  <= WIND_RESET;
            r_c0    <= C0_RESET;
            r_c1    <= C1_RESET;
            r_c2    <= C2_RESET;
            r_c3    <= C3_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HOVER_POWER: r_hover <= i_cfg_data[HOVER_W-1:0];
                REG_WIND_SPEED:  r_wind  <= i_cfg_data[VEL_W-1:0];
                REG_COEF_ZERO:   r_c0    <= i_cfg_data[COEF_W-1:0];
                REG_COEF_ONE:    r_c1    <= i_cfg_data[COEF_W-1:0];
                REG_COEF_TWO:    r_c2    <= i_cfg_data[COEF_W-1:0];
                REG_COEF_THREE:  r_c3    <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Product register of the shared multiplier.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_have_ref <= 1'b0;
            r_sum      <= '0;
            r_last_n   <= '0;
            r_last_e   <= '0;
            r_last_d   <= '0;
            r_last_vn  <= '0;
            r_last_ve  <= '0;
            r_last_vd  <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            // A taken result frees the output register unless a new one is loaded.
            if (r_ovalid && o_result.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_valid_s <= i_item.sample_valid;
                        r_restart <= i_item.restart;
                        r_cur_n   <= i_item.sample_valid ? i_item.pos_north : r_last_n;
                        r_cur_e   <= i_item.sample_valid ? i_item.pos_east  : r_last_e;
                        r_cur_d   <= i_item.sample_valid ? i_item.pos_down  : r_last_d;
                        r_cur_vn  <= i_item.sample_valid ? i_item.vel_north : r_last_vn;
                        r_cur_ve  <= i_item.sample_valid ? i_item.vel_east  : r_last_ve;
                        r_cur_vd  <= i_item.sample_valid ? i_item.vel_down  : r_last_vd;
                        r_acc     <= '0;
                        r_cnt     <= '0;
                        r_state   <= S_VSQ;
                    end
                end
                S_VSQ: begin
                    if (r_cnt[0]) begin
                        r_acc <= r_acc + r_prod;
                    end
                    if (r_cnt == 7'd5) begin
                        r_cnt   <= '0;
                        r_state <= S_GSQRT;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_GSQRT: begin
                    if (r_cnt == 7'd0) begin
                        r_cnt <= 7'd1;
                    end else if (sq_done) begin
                        r_gs   <= sq_root[GS_W-1:0];
                        r_air  <= 27'({2'b00, sq_root[GS_W-1:0]}) - 27'(r_wind);
                        r_p    <= 32'(r_c3);
                        r_acc  <= '0;
                        r_cnt  <= '0;
                        r_calc <= 1'b0;
                        if (r_have_ref && !r_restart && (sq_root != '0)) begin
                            r_state <= S_POLY;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_POLY: begin
                    if (r_cnt[0]) begin
                        r_p <= poly_sat;
                    end
                    if (r_cnt == 7'd5) begin
                        r_cnt   <= '0;
                        r_state <= S_PWR;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_PWR: begin
                    if (r_cnt[0]) begin
                        r_mag   <= r_prod[47:0];
                        r_neg   <= r_p[31];
                        r_cnt   <= '0;
                        r_state <= S_DSQ;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DSQ: begin
                    if (r_cnt[0]) begin
                        r_acc <= r_acc + r_prod;
                    end
                    if (r_cnt == 7'd5) begin
                        r_cnt   <= '0;
                        r_state <= S_DSQRT;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DSQRT: begin
                    if (r_cnt == 7'd0) begin
                        r_cnt <= 7'd1;
                    end else if (sq_done) begin
                        r_dist  <= sq_root;
                        r_num   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    if (r_cnt[0]) begin
                        r_num <= r_num + (r_cnt[1] ? (NUM_W'(r_prod) << 24) : NUM_W'(r_prod));
                    end
                    if (r_cnt == 7'd3) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_big   <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? 38'(div_t - div_d) : 38'(div_t);
                    r_q   <= {r_q[38:0], div_ge};
                    r_big <= r_big | r_q[39];
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    if (r_cnt == 7'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_calc  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_odelta  <= delta;
                        r_ototal  <= total_sat;
                        r_ogs     <= r_gs;
                        r_ozero   <= (r_gs == '0);
                        r_oheld   <= !r_valid_s;
                        r_sum     <= total_sat;
                        r_last_n  <= r_cur_n;
                        r_last_e  <= r_cur_e;
                        r_last_d  <= r_cur_d;
                        r_last_vn <= r_cur_vn;
                        r_last_ve <= r_cur_ve;
                        r_last_vd <= r_cur_vd;
                        if (r_valid_s) begin
                            r_have_ref <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready          = (r_state == S_IDLE);
    assign o_result.valid        = r_ovalid;
    assign o_result.delta_energy = r_odelta;
    assign o_result.total_energy = r_ototal;
    assign o_result.ground_speed = r_ogs;
    assign o_result.zero_speed   = r_ozero;
    assign o_result.sample_held  = r_oheld;

endmodule
